FILE: hdl/tlid_pkg.sv
//------------------------------------------------------------------------------
// tlid_pkg
// Shared constants, types and reset tables for the profile density interpolator.
//------------------------------------------------------------------------------
package tlid_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int ALT_W       = 18;
   localparam int LOGD_W      = 23;
   localparam int CNT_W       = 6;
   localparam int STD_POINTS  = 30;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // One table row as stored in memory.
   typedef struct packed {
      logic [ALT_W-1:0]  alt;
      logic [LOGD_W-1:0] logd;
   } row_type;

   // Reset contents of the profile table.
   function automatic row_type std_row(input logic [IDX_W-1:0] i);
      row_type r;
      r.alt  = '0;
      r.logd = '0;
      case (i)
         5'd0:  begin r.alt = 18'd0;      r.logd = 23'd4229901; end
         5'd1:  begin r.alt = 18'd5000;   r.logd = 23'd4176620; end
         5'd2:  begin r.alt = 18'd10000;  r.logd = 23'd4122042; end
         5'd3:  begin r.alt = 18'd15000;  r.logd = 23'd4050952; end
         5'd4:  begin r.alt = 18'd20000;  r.logd = 23'd3976871; end
         5'd5:  begin r.alt = 18'd25000;  r.logd = 23'd3901430; end
         5'd6:  begin r.alt = 18'd30000;  r.logd = 23'd3827966; end
         5'd7:  begin r.alt = 18'd35000;  r.logd = 23'd3754450; end
         5'd8:  begin r.alt = 18'd40000;  r.logd = 23'd3683497; end
         5'd9:  begin r.alt = 18'd45000;  r.logd = 23'd3616424; end
         5'd10: begin r.alt = 18'd50000;  r.logd = 23'd3554784; end
         5'd11: begin r.alt = 18'd55000;  r.logd = 23'd3499023; end
         5'd12: begin r.alt = 18'd60000;  r.logd = 23'd3440058; end
         5'd13: begin r.alt = 18'd64000;  r.logd = 23'd3394991; end
         5'd14: begin r.alt = 18'd68000;  r.logd = 23'd3347968; end
         5'd15: begin r.alt = 18'd72000;  r.logd = 23'd3296723; end
         5'd16: begin r.alt = 18'd76000;  r.logd = 23'd3241122; end
         5'd17: begin r.alt = 18'd80000;  r.logd = 23'd3179661; end
         5'd18: begin r.alt = 18'd84000;  r.logd = 23'd3112944; end
         5'd19: begin r.alt = 18'd88000;  r.logd = 23'd3042833; end
         5'd20: begin r.alt = 18'd92000;  r.logd = 23'd2969613; end
         5'd21: begin r.alt = 18'd96000;  r.logd = 23'd2898965; end
         5'd22: begin r.alt = 18'd100000; r.logd = 23'd2833885; end
         5'd23: begin r.alt = 18'd108000; r.logd = 23'd2721852; end
         5'd24: begin r.alt = 18'd114000; r.logd = 23'd2646288; end
         5'd25: begin r.alt = 18'd120000; r.logd = 23'd2573327; end
         5'd26: begin r.alt = 18'd126000; r.logd = 23'd2510471; end
         5'd27: begin r.alt = 18'd132000; r.logd = 23'd2455947; end
         5'd28: begin r.alt = 18'd140000; r.logd = 23'd2391885; end
         5'd29: begin r.alt = 18'd150000; r.logd = 23'd2327704; end
         default: begin r.alt = '0; r.logd = '0; end
      endcase
      return r;
   endfunction

endpackage

FILE: hdl/tlid_exp2.sv
//------------------------------------------------------------------------------
// tlid_exp2
// Iterative exp2 fraction: Taylor series of exp(u*ln2) to eighth order, one
// multiply and one divide-by-k per term.
//------------------------------------------------------------------------------
module tlid_exp2 (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] u,
   output logic        done,
   output logic [15:0] frac
);
   import tlid_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_T    = 2'd1;
   localparam logic [1:0] S_MUL  = 2'd2;
   localparam logic [1:0] S_DIV  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [3:0]  k_ff, k_in;
   logic [31:0] t_ff, t_in;
   logic [31:0] term_ff, term_in;
   logic [35:0] sum_ff, sum_in;
   logic [63:0] prod_ff, prod_in;
   logic        done_ff, done_in;
   logic [19:0] rnd;
   logic [32:0] magic;
   logic [64:0] qprod;
   logic [31:0] qrecip;

   // Exact floor division by three, five, six or seven by a reciprocal multiply.
   always_comb begin
      case (k_ff)
         4'd5:    magic = 33'h0_CCCC_CCCD;
         4'd7:    magic = 33'h1_2492_4925;
         default: magic = 33'h0_AAAA_AAAB;
      endcase
      qprod = 65'(prod_ff[63:32]) * 65'(magic);
      case (k_ff)
         4'd3:    qrecip = qprod[64:33];
         4'd7:    qrecip = 32'(qprod[64:35]);
         default: qrecip = 32'(qprod[64:34]);
      endcase
   end

   // Term update: multiply by t, then divide by k with a shift or a reciprocal.
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      t_in     = t_ff;
      term_in  = term_ff;
      sum_in   = sum_ff;
      prod_in  = prod_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               prod_in  = 64'({16'd0, u} * {16'd0, LN2_Q32});
               state_in = S_T;
            end
         end
         S_T: begin
            t_in     = prod_ff[47:16];
            term_in  = 32'hFFFF_FFFF;
            sum_in   = 36'h1_0000_0000;
            k_in     = 4'd1;
            state_in = S_MUL;
         end
         S_MUL: begin
            // First term is 2^32 exactly: term*t>>32 equals t.
            if (k_ff == 4'd1) prod_in = {t_ff, 32'd0};
            else              prod_in = 64'(term_ff) * 64'(t_ff);
            state_in = S_DIV;
         end
         S_DIV: begin
            case (k_ff) inside
               4'd1:                   term_in = prod_ff[63:32];
               4'd2:                   term_in = 32'(prod_ff[63:33]);
               4'd3, 4'd5, 4'd6, 4'd7: term_in = qrecip;
               4'd4:                   term_in = 32'(prod_ff[63:34]);
               default:                term_in = 32'(prod_ff[63:35]);
            endcase
            sum_in = sum_ff + 36'(term_in);
            if (k_ff == 4'd8) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               k_in     = k_ff + 4'd1;
               state_in = S_MUL;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      k_ff    <= k_in;
      t_ff    <= t_in;
      term_ff <= term_in;
      sum_ff  <= sum_in;
      prod_ff <= prod_in;
   end

   // Round to Q.16 and clamp.
   assign rnd  = 20'((sum_ff - 36'h1_0000_0000 + 36'd32768) >> 16);
   assign done = done_ff;
   assign frac = (rnd > 20'd65535) ? 16'hFFFF : rnd[15:0];

endmodule

FILE: hdl/table_log_interp_density_core.sv
//------------------------------------------------------------------------------
// table_log_interp_density_core
// Profile table density interpolator: binary search over a table memory,
// serial divide for the weight, log-domain blend and iterative exp2.
//
//  channel | dir | beat contents
//  req_    | in  | tdata: action, entry_index, entry_altitude,
//          |     |        entry_log_density, query_altitude
//  rsp_    | out | tdata: ratio_exponent, ratio_fraction, out_of_range
//  csr_    | in  | entry_count, written when csr_wr_en is high
//
// A load writes its entry on acceptance. A query reads the end entries, takes
// up to five search steps, reads the bracket rows, runs a 17-step restoring
// divide, blends in the log domain, runs the eight-term exp2 series and then
// presents the result. An out-of-range query answers after the end-entry check.
// Reset loads the standard profile by a pass that writes every table entry,
// with req_tready low.
// A result waits in the output register while rsp_tready is low.
//------------------------------------------------------------------------------
module table_log_interp_density_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] action, [5:1] entry_index, [23:6] entry_altitude,
   // [46:24] entry_log_density, [64:47] query_altitude, [71:65] zero
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [6:0] ratio_exponent, [22:7] ratio_fraction, [23] out_of_range
   output logic [23:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [tlid_pkg::CNT_W-1:0] csr_wr_data
);
   import tlid_pkg::*;

   localparam logic [3:0] S_INIT = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_R0   = 4'd2;
   localparam logic [3:0] S_RN   = 4'd3;
   localparam logic [3:0] S_CHK  = 4'd4;
   localparam logic [3:0] S_SRCH = 4'd5;
   localparam logic [3:0] S_RLO  = 4'd6;
   localparam logic [3:0] S_RHI  = 4'd7;
   localparam logic [3:0] S_DIV  = 4'd8;
   localparam logic [3:0] S_MUL  = 4'd9;
   localparam logic [3:0] S_SUM  = 4'd10;
   localparam logic [3:0] S_EXP  = 4'd11;
   localparam logic [3:0] S_OUT  = 4'd12;
   localparam logic [3:0] S_SWR  = 4'd13;

   row_type mem [TABLE_DEPTH];
   row_type rd_ff;
   logic [IDX_W-1:0] raddr;
   logic             we;
   logic [IDX_W-1:0] waddr;
   row_type          wdata;

   logic [3:0]  state_ff, state_in;
   logic [IDX_W:0] init_ff, init_in;
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W:0] n_ff, n_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [ALT_W-1:0] h_ff, h_in;
   logic [LOGD_W-1:0] ld0_ff, ld0_in;
   row_type lorow_ff, lorow_in;
   logic [ALT_W-1:0] span_ff, span_in;
   logic [ALT_W:0] rem_ff, rem_in;
   logic [16:0] w_ff, w_in;
   logic [4:0]  dstep_ff, dstep_in;
   logic signed [42:0] acc_ff, acc_in;
   logic signed [24:0] dld_ff, dld_in;
   logic [23:0] rsp_ff, rsp_in;
   logic        rv_ff, rv_in;
   logic [6:0]  e_ff, e_in;
   logic        exp_start;
   logic        exp_start_ff;
   logic        exp_done;
   logic [15:0] exp_frac;
   logic [15:0] u_ff, u_in;
   logic [IDX_W:0] mid;
   logic [ALT_W:0] rem2;
   logic signed [43:0] biased;
   logic signed [27:0] lval;
   logic [ALT_W-1:0] d;
   logic [IDX_W:0] nclamp;

   // Table memory, one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   // Clamp the configured count to the legal table size.
   always_comb begin
      if (count_ff < CNT_W'(2))               nclamp = (IDX_W+1)'(2);
      else if (count_ff > CNT_W'(TABLE_DEPTH)) nclamp = (IDX_W+1)'(TABLE_DEPTH);
      else                                    nclamp = (IDX_W+1)'(count_ff);
   end

   assign mid  = (lo_ff + hi_ff) >> 1;
   assign rem2 = {rem_ff[ALT_W-1:0], 1'b0};
   assign biased = 44'(acc_ff) + 44'(32768);
   assign lval   = 28'(biased >>> 16);
   assign d = (h_ff >= lorow_ff.alt) ? (h_ff - lorow_ff.alt) : '0;

   // Main sequencer.
   always_comb begin
      state_in = state_ff;
      init_in  = init_ff;
      n_in = n_ff; lo_in = lo_ff; hi_in = hi_ff;
      h_in = h_ff; ld0_in = ld0_ff; lorow_in = lorow_ff;
      span_in = span_ff; rem_in = rem_ff; w_in = w_ff; dstep_in = dstep_ff;
      acc_in = acc_ff; dld_in = dld_ff; e_in = e_ff; u_in = u_ff;
      rsp_in = rsp_ff; rv_in = rv_ff;
      exp_start = 1'b0;
      we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            we    = 1'b1;
            waddr = init_ff[IDX_W-1:0];
            wdata = std_row(init_ff[IDX_W-1:0]);
            init_in = init_ff + 1'b1;
            if (init_ff == (IDX_W+1)'(TABLE_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid && !rv_ff) begin
               if (req_tdata[0] == ACT_LOAD) begin
                  we    = 1'b1;
                  waddr = req_tdata[IDX_W:1];
                  wdata.alt  = req_tdata[23:6];
                  wdata.logd = req_tdata[46:24];
                  state_in = S_SWR;
               end else begin
                  h_in  = req_tdata[64:47];
                  n_in  = nclamp;
                  raddr = '0;
                  state_in = S_R0;
               end
            end
         end
         S_SWR: state_in = S_IDLE;
         S_R0: begin
            // rd_ff holds entry 0.
            ld0_in = rd_ff.logd;
            lorow_in = rd_ff;
            raddr  = IDX_W'(n_ff - 1'b1);
            state_in = S_RN;
         end
         S_RN: begin
            if (h_ff < lorow_ff.alt || h_ff > rd_ff.alt) begin
               rsp_in = {1'b1, 16'd0, 7'd0};
               state_in = S_OUT;
            end else begin
               lo_in = '0;
               hi_in = n_ff - 1'b1;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (hi_ff == lo_ff + 1'b1) begin
               raddr = lo_ff[IDX_W-1:0];
               state_in = S_RLO;
            end else begin
               raddr = mid[IDX_W-1:0];
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (h_ff < rd_ff.alt) hi_in = mid; else lo_in = mid;
            state_in = S_CHK;
         end
         S_RLO: begin
            lorow_in = rd_ff;
            raddr = hi_ff[IDX_W-1:0];
            state_in = S_RHI;
         end
         S_RHI: begin
            dld_in = 25'($signed({2'b0, rd_ff.logd}) - $signed({2'b0, lorow_ff.logd}));
            acc_in = 43'($signed({2'b0, lorow_ff.logd}) - $signed({2'b0, ld0_ff})) <<< 16;
            w_in = '0;
            dstep_in = '0;
            if (rd_ff.alt > lorow_ff.alt) begin
               span_in = rd_ff.alt - lorow_ff.alt;
               rem_in  = {1'b0, (d > (rd_ff.alt - lorow_ff.alt)) ?
                          (rd_ff.alt - lorow_ff.alt) : d};
               state_in = S_DIV;
            end else begin
               state_in = S_MUL;
            end
         end
         S_DIV: begin
            // Restoring division of d*65536 by span, one quotient bit a cycle.
            if (dstep_ff == 5'd0) begin
               // Integer quotient bit: d <= span, so at most 1.
               if (rem_ff >= {1'b0, span_ff}) begin
                  rem_in = rem_ff - {1'b0, span_ff};
                  w_in = 17'd1;
               end
            end else begin
               if (rem2 >= {1'b0, span_ff}) begin
                  rem_in = rem2 - {1'b0, span_ff};
                  w_in = {w_ff[15:0], 1'b1};
               end else begin
                  rem_in = rem2;
                  w_in = {w_ff[15:0], 1'b0};
               end
            end
            dstep_in = dstep_ff + 5'd1;
            if (dstep_ff == 5'd16) state_in = S_MUL;
         end
         S_MUL: begin
            acc_in = acc_ff + 43'(dld_ff) * 43'($signed({1'b0, w_ff}));
            state_in = S_SUM;
         end
         S_SUM: begin
            if (lval >= 28'sd65536) begin
               rsp_in = {1'b0, 16'hFFFF, 7'd0};
               state_in = S_OUT;
            end else if (lval < -28'sd4128768) begin
               rsp_in = {1'b0, 16'd0, 7'h41};
               state_in = S_OUT;
            end else begin
               e_in = lval[22:16];
               u_in = lval[15:0];
               exp_start = 1'b1;
               state_in = S_EXP;
            end
         end
         S_EXP: begin
            if (exp_done) begin
               rsp_in = {1'b0, exp_frac, e_ff};
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_ff      <= '0;
         rv_ff        <= 1'b0;
         exp_start_ff <= 1'b0;
         count_ff     <= CNT_W'(STD_POINTS);
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         rv_ff        <= rv_in;
         exp_start_ff <= exp_start;
         if (csr_wr_en) count_ff <= csr_wr_data;
      end
      n_ff <= n_in; lo_ff <= lo_in; hi_ff <= hi_in;
      h_ff <= h_in; ld0_ff <= ld0_in; lorow_ff <= lorow_in;
      span_ff <= span_in; rem_ff <= rem_in; w_ff <= w_in; dstep_ff <= dstep_in;
      acc_ff <= acc_in; dld_ff <= dld_in; e_ff <= e_in; u_ff <= u_in;
      rsp_ff <= rsp_in;
   end

   // The series starts in the cycle after the blend ends, once u_ff holds the fraction.
   tlid_exp2 u_exp2 (
      .clock (clock),
      .reset (reset),
      .start (exp_start_ff),
      .u     (u_ff),
      .done  (exp_done),
      .frac  (exp_frac)
   );

   assign req_tready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

FILE: hdl/tlid_checker.sv
//------------------------------------------------------------------------------
// tlid_checker
// Port-level checks for the density interpolator, bound to the top level.
//------------------------------------------------------------------------------
module tlid_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [71:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   // A result beat holds until taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");

   // No new request while a result waits.
   a_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken with result pending");

   // Out-of-range results carry zero payload.
   a_oor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[23] |-> rsp_tdata[22:0] == 23'd0)
      else $error("out-of-range result not zero");

   // An accepted request clears ready next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready held after accept");
endmodule

bind table_log_interp_density_core tlid_checker u_tlid_checker (.*);

FILE: tb/sv/table_log_interp_density_core_tb.sv
//------------------------------------------------------------------------------
// table_log_interp_density_core_tb
// Self-checking bench for the profile density interpolator. A directed table
// of loads and queries is followed by random table reloads and queries. Every
// query result is checked field by field against an in-bench density model or a
// typed-in result, under several entry counts and several idle and stall patterns.
//------------------------------------------------------------------------------
module table_log_interp_density_core_tb;
   import tlid_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;

   // One expected query result.
   typedef struct packed {
      logic [6:0]  exponent;
      logic [15:0] fraction;
      logic        oor;
   } density_type;

   // One directed row; has_known marks rows with a typed-in result.
   typedef struct {
      logic        act;
      logic [4:0]  idx;
      logic [17:0] alt;
      logic [22:0] logd;
      logic [17:0] qalt;
      logic        has_known;
      density_type known;
   } dir_row_type;

   // Bench copy of the block state.
   logic [ALT_W-1:0]  alt_mem[TABLE_DEPTH];
   logic [LOGD_W-1:0] logd_mem[TABLE_DEPTH];
   logic [CNT_W-1:0]  count_reg;

   density_type density_queue[$];
   int          mismatches;
   bit          timed_out;
   int          send_idle_pct;
   int          stall_pct;
   bit          hold_rsp;
   int          hold_cycles;

   table_log_interp_density_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Rounded (2^(u/65536) - 1) * 65536 by a truncated series in Q.32.
   function automatic logic [15:0] exp2_frac(input logic [15:0] u);
      logic [63:0] t;
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] f;
      t = ({48'd0, u} * 64'd2977044472) >> 16;
      sum = 64'd1 << 32;
      term = 64'd1 << 32;
      for (int k = 1; k <= 8; k++) begin
         term = ((term * t) >> 32) / k;
         sum = sum + term;
      end
      f = (sum - (64'd1 << 32) + 64'd32768) >> 16;
      if (f > 64'd65535) f = 64'd65535;
      return f[15:0];
   endfunction

   // Density ratio to entry 0 at altitude h, from the bench table copy.
   function automatic density_type predict_density(input logic [17:0] h);
      density_type r;
      int unsigned n, lo, hi, mid, span, d;
      longint unsigned w, biased, lb;
      longint acc, lval, e;
      r = '0;
      n = count_reg;
      if (n < 2) n = 2;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      if (h < alt_mem[0] || h > alt_mem[n-1]) begin
         r.oor = 1'b1;
         return r;
      end
      lo = 0;
      hi = n - 1;
      while (hi != lo + 1) begin
         mid = (lo + hi) / 2;
         if (h < alt_mem[mid]) hi = mid; else lo = mid;
      end
      w = 0;
      if (alt_mem[hi] > alt_mem[lo]) begin
         span = alt_mem[hi] - alt_mem[lo];
         d = (h >= alt_mem[lo]) ? h - alt_mem[lo] : 0;
         if (d > span) d = span;
         w = (longint'(d) << 16) / span;
      end
      acc = (longint'(logd_mem[lo]) - longint'(logd_mem[0])) * 65536
          + (longint'(logd_mem[hi]) - longint'(logd_mem[lo])) * longint'(w);
      biased = longint'(acc + (longint'(1) << 41)) + 32768;
      lval = longint'(biased >> 16) - (longint'(1) << 25);
      if (lval >= 65536) begin
         e = 0;
         r.fraction = 16'hFFFF;
      end else if (lval < -63 * 65536) begin
         e = -63;
         r.fraction = 16'd0;
      end else begin
         lb = lval + 64 * 65536;
         e = longint'(lb >> 16) - 64;
         r.fraction = exp2_frac(lb[15:0]);
      end
      r.exponent = 7'(128 + e);
      return r;
   endfunction

   // Sends one beat; a query pushes its expected density when accepted.
   task automatic send_beat(input logic act, input logic [4:0] idx,
                            input logic [17:0] alt, input logic [22:0] logd,
                            input logic [17:0] qalt);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, qalt, logd, alt, idx, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (act == ACT_QUERY) begin
         density_queue.push_back(predict_density(qalt));
      end else begin
         alt_mem[idx]  = alt;
         logd_mem[idx] = logd;
      end
   endtask

   // Waits for every expected result plus the longest query latency.
   task automatic drain;
      req_tvalid <= 1'b0;
      while (density_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_count(input logic [CNT_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      count_reg = v;
   endtask

   // Mostly queries within the active span, with occasional reloads.
   task automatic random_beat;
      logic [17:0] top;
      int unsigned n;
      n = (count_reg < 2) ? 2 : count_reg;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      top = alt_mem[n-1];
      if ($urandom_range(99) < 12) begin
         send_beat(ACT_LOAD, 5'($urandom), 18'($urandom), 23'($urandom), 18'($urandom));
      end else if ($urandom_range(99) < 85) begin
         send_beat(ACT_QUERY, 5'($urandom), 18'($urandom), 23'($urandom),
                   18'($urandom_range(top + 1)));
      end else begin
         send_beat(ACT_QUERY, 5'($urandom), 18'($urandom), 23'($urandom), 18'($urandom));
      end
   endtask

   // Result side: random stall, check against the oldest expectation.
   always @(posedge clock) begin
      density_type got;
      density_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.exponent = rsp_tdata[6:0];
            got.fraction = rsp_tdata[22:7];
            got.oor      = rsp_tdata[23];
            if (density_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected result beat %h", rsp_tdata);
            end else begin
               want = density_queue.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                              $signed(want.exponent), want.fraction, want.oor,
                              $signed(got.exponent), got.fraction, got.oor);
               end
            end
         end
         rsp_tready <= !hold_rsp && !(stall_pct > 0 && $urandom_range(99) < stall_pct);
      end
   end

   // Long receiver hold-off, counted here in cycles.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         hold_rsp    <= 1'b1;
      end else begin
         hold_rsp <= 1'b0;
      end
   end

   initial begin
      #20000000;
      timed_out = 1'b1;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      dir_row_type rows[$];
      dir_row_type row;
      int pct_s[4];
      int pct_r[4];
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      hold_rsp    = 1'b0;
      hold_cycles = 0;
      send_idle_pct = 0;
      stall_pct   = 0;
      mismatches  = 0;
      timed_out   = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         alt_mem[i]  = std_row(5'(i)).alt;
         logd_mem[i] = std_row(5'(i)).logd;
      end
      count_reg = 6'd30;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed rows: ground level, table top, above top, extremes, odd tables.
      rows = '{
         '{ACT_QUERY, 5'd0, 18'd0, 23'd0, 18'd0, 1'b1, '{7'd0, 16'd0, 1'b0}},
         '{ACT_QUERY, 5'd31, 18'h3FFFF, 23'h7FFFFF, 18'd150000, 1'b0, '0},
         '{ACT_QUERY, 5'd0, 18'd0, 23'd0, 18'd150001, 1'b1, '{7'd0, 16'd0, 1'b1}},
         '{ACT_QUERY, 5'd0, 18'd0, 23'd0, 18'h3FFFF, 1'b1, '{7'd0, 16'd0, 1'b1}},
         '{ACT_QUERY, 5'd0, 18'd0, 23'd0, 18'd77777, 1'b0, '0},
         '{ACT_QUERY, 5'd0, 18'd0, 23'd0, 18'd2500, 1'b0, '0},
         // Steep drop below two to the minus 63 saturates low.
         '{ACT_LOAD, 5'd29, 18'h3FFFF, 23'd0, 18'd0, 1'b0, '0},
         '{ACT_QUERY, 5'd0, 18'd0, 23'd0, 18'h3FFFF, 1'b1, '{7'h41, 16'd0, 1'b0}},
         // Rising density saturates high.
         '{ACT_LOAD, 5'd1, 18'd5000, 23'h7FFFFF, 18'd0, 1'b0, '0},
         '{ACT_QUERY, 5'd0, 18'd0, 23'd0, 18'd5000, 1'b1, '{7'd0, 16'hFFFF, 1'b0}},
         '{ACT_QUERY, 5'd0, 18'd0, 23'd0, 18'd3000, 1'b0, '0},
         // Flat and descending interval gives a zero weight.
         '{ACT_LOAD, 5'd2, 18'd5000, 23'd4000000, 18'd0, 1'b0, '0},
         '{ACT_LOAD, 5'd3, 18'd1000, 23'd100, 18'd0, 1'b0, '0},
         '{ACT_QUERY, 5'd0, 18'd0, 23'd0, 18'd5000, 1'b0, '0},
         '{ACT_QUERY, 5'd0, 18'd0, 23'd0, 18'd12000, 1'b0, '0},
         '{ACT_LOAD, 5'd30, 18'd200000, 23'd1, 18'd0, 1'b0, '0},
         '{ACT_LOAD, 5'd31, 18'd0, 23'd0, 18'd0, 1'b0, '0},
         '{ACT_QUERY, 5'd0, 18'd0, 23'd0, 18'd160000, 1'b0, '0}
      };
      foreach (rows[i]) begin
         row = rows[i];
         send_beat(row.act, row.idx, row.alt, row.logd, row.qalt);
         if (row.act == ACT_QUERY && row.has_known && density_queue.size() != 0)
            density_queue[$] = row.known;
      end
      drain();

      // Register extremes and settings, then random beats under each pattern.
      pct_s = '{0, 86, 0, 13};
      pct_r = '{0, 0, 86, 13};
      for (int ph = 0; ph < 8; ph++) begin
         drain();
         case (ph)
            0: write_count(6'd32);
            1: write_count(6'd2);
            2: write_count(6'd0);
            3: write_count(6'd63);
            4: write_count(6'd17);
            default: write_count(6'($urandom_range(2, 32)));
         endcase
         send_idle_pct = pct_s[ph % 4];
         stall_pct = pct_r[ph % 4];
         if (ph == 4) hold_cycles = 600;
         for (int i = 0; i < 150; i++) random_beat();
      end

      // Sender waits for every result, then one last burst.
      drain();
      send_idle_pct = 0;
      stall_pct = 0;
      for (int i = 0; i < 20; i++) random_beat();
      drain();
      if (mismatches == 0 && density_queue.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/tlid_pkg.sv
hdl/tlid_exp2.sv
hdl/table_log_interp_density_core.sv
hdl/tlid_checker.sv
tb/sv/table_log_interp_density_core_tb.sv
